// ===== hw/rtl/vgm_pkg.sv =====
package vgm_pkg;

    localparam int unsigned HEADER_BYTES = 64;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_OPCODE  = 3'd1,
        PH_AY_ADDR = 3'd2,
        PH_AY_DATA = 3'd3,
        PH_WAIT_LO = 3'd4,
        PH_WAIT_HI = 3'd5,
        PH_SKIP    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_WAIT  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    localparam logic [7:0] OP_AY_WRITE = 8'hA0;
    localparam logic [7:0] OP_WAIT16   = 8'h61;
    localparam logic [7:0] OP_WAIT735  = 8'h62;
    localparam logic [7:0] OP_WAIT882  = 8'h63;
    localparam logic [7:0] OP_OVERRIDE = 8'h64;
    localparam logic [7:0] OP_END      = 8'h66;
    localparam logic [7:0] OP_DATA_BLK = 8'h67;
    localparam logic [7:0] OP_PCM_SEEK = 8'hE0;
    localparam logic [3:0] OP_WAIT_N1  = 4'h7;
    localparam logic [3:0] OP_WAIT_N   = 4'h8;

    localparam logic [15:0] WAIT_NTSC = 16'd735;
    localparam logic [15:0] WAIT_PAL  = 16'd882;

    localparam logic [2:0] SKIP_OVERRIDE = 3'd3;
    localparam logic [2:0] SKIP_DATA_BLK = 3'd2;
    localparam logic [2:0] SKIP_PCM_SEEK = 3'd4;

    localparam logic REG_STREAM_LENGTH = 1'b0;

endpackage

// ===== hw/rtl/vgm_command_stream_parser.sv =====
// A result beat appears on the master side in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the single output register stalls intake only while a
// result is held and the master side is not ready.
// Reset: synchronous, active low; clears the parser state, the stream length and the
// output valid flag.
module vgm_command_stream_parser
    import vgm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    // results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata, // [7:0] reg_address, [15:8] reg_value, [31:16] wait_samples
    output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

    logic [31:0] r_stream_length;
    logic [31:0] r_bytes_seen, n_bytes_seen;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_opcode, n_opcode;
    logic [2:0]  r_left, n_left;
    logic [7:0]  r_first, n_first;
    logic        r_stopped, n_stopped;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_addr;
    logic [7:0]  r_out_value;
    logic [15:0] r_out_wait;

    logic        in_beat;
    logic        live;
    logic [31:0] bytes_inc;
    logic [2:0]  left_dec;
    logic        res_valid;
    t_kind       res_kind;
    logic [7:0]  res_addr;
    logic [7:0]  res_value;
    logic [15:0] res_wait;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_STREAM_LENGTH) ? r_stream_length : 32'd0;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign live          = !r_stopped && (r_bytes_seen < r_stream_length);
    assign bytes_inc     = r_bytes_seen + 32'd1;
    assign left_dec      = (r_left != 3'd0) ? r_left - 3'd1 : 3'd0;

    // next parser state
    always_comb begin
        n_bytes_seen = r_bytes_seen;
        n_phase      = r_phase;
        n_opcode     = r_opcode;
        n_left       = r_left;
        n_first      = r_first;
        n_stopped    = r_stopped;
        if (in_beat && !r_stopped) begin
            if (!live) begin
                n_stopped = 1'b1;
            end else begin
                n_bytes_seen = bytes_inc;
                case (r_phase)
                    PH_HEADER: begin
                        if (bytes_inc >= 32'(HEADER_BYTES)) n_phase = PH_OPCODE;
                    end
                    PH_AY_ADDR: begin
                        n_first = s_axis_tdata;
                        n_phase = PH_AY_DATA;
                    end
                    PH_AY_DATA: n_phase = PH_OPCODE;
                    PH_WAIT_LO: begin
                        n_first = s_axis_tdata;
                        n_phase = PH_WAIT_HI;
                    end
                    PH_WAIT_HI: n_phase = PH_OPCODE;
                    PH_SKIP: begin
                        n_left = left_dec;
                        if (left_dec == 3'd0) n_phase = PH_OPCODE;
                    end
                    default: begin
                        // opcode phase, also taken for the unused phase code
                        n_opcode = s_axis_tdata;
                        n_phase  = PH_OPCODE;
                        case (s_axis_tdata)
                            OP_AY_WRITE: n_phase = PH_AY_ADDR;
                            OP_WAIT16:   n_phase = PH_WAIT_LO;
                            OP_OVERRIDE: begin
                                n_left  = SKIP_OVERRIDE;
                                n_phase = PH_SKIP;
                            end
                            OP_DATA_BLK: begin
                                n_left  = SKIP_DATA_BLK;
                                n_phase = PH_SKIP;
                            end
                            OP_PCM_SEEK: begin
                                n_left  = SKIP_PCM_SEEK;
                                n_phase = PH_SKIP;
                            end
                            OP_END:  n_stopped = 1'b1;
                            default: ;
                        endcase
                    end
                endcase
            end
        end
    end

    // result for the current byte
    always_comb begin
        res_valid = 1'b0;
        res_kind  = KIND_WAIT;
        res_addr  = 8'd0;
        res_value = 8'd0;
        res_wait  = 16'd0;
        if (live) begin
            case (r_phase)
                PH_HEADER, PH_AY_ADDR, PH_WAIT_LO: ;
                PH_AY_DATA: begin
                    res_valid = 1'b1;
                    res_kind  = KIND_WRITE;
                    res_addr  = r_first;
                    res_value = s_axis_tdata;
                end
                PH_WAIT_HI: begin
                    res_valid = 1'b1;
                    res_wait  = {s_axis_tdata, r_first};
                end
                PH_SKIP: begin
                    if (left_dec == 3'd0 && r_opcode == OP_OVERRIDE) begin
                        res_valid = 1'b1;
                        res_wait  = WAIT_PAL;
                    end
                end
                default: begin
                    if (s_axis_tdata[7:4] == OP_WAIT_N1) begin
                        res_valid = 1'b1;
                        res_wait  = 16'(s_axis_tdata[3:0]) + 16'd1;
                    end else if (s_axis_tdata[7:4] == OP_WAIT_N) begin
                        res_valid = 1'b1;
                        res_wait  = 16'(s_axis_tdata[3:0]);
                    end else begin
                        case (s_axis_tdata)
                            OP_WAIT735: begin
                                res_valid = 1'b1;
                                res_wait  = WAIT_NTSC;
                            end
                            OP_WAIT882: begin
                                res_valid = 1'b1;
                                res_wait  = WAIT_PAL;
                            end
                            OP_END: begin
                                res_valid = 1'b1;
                                res_kind  = KIND_END;
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= 32'd0;
            r_bytes_seen    <= 32'd0;
            r_phase         <= PH_HEADER;
            r_opcode        <= 8'd0;
            r_left          <= 3'd0;
            r_first         <= 8'd0;
            r_stopped       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_STREAM_LENGTH) r_stream_length <= pwdata;
            r_bytes_seen <= n_bytes_seen;
            r_phase      <= n_phase;
            r_opcode     <= n_opcode;
            r_left       <= n_left;
            r_first      <= n_first;
            r_stopped    <= n_stopped;
            // load a fresh result, else drop the one just taken
            if (in_beat && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && res_valid) begin
            r_out_kind  <= res_kind;
            r_out_addr  <= res_addr;
            r_out_value <= res_value;
            r_out_wait  <= res_wait;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_wait, r_out_value, r_out_addr};
    assign m_axis_tuser  = r_out_kind;

endmodule

// ===== hw/rtl/vgm_checker.sv =====
module vgm_checker
    import vgm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // intake stops only behind a stalled result
    a_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("intake stalled without a pending result");

    // nothing follows the end of data
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_END |=> !m_axis_tvalid)
        else $error("result after end of data");

    // fields that do not belong to the kind are zero
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == KIND_WRITE && m_axis_tdata[31:16] == 16'd0) ||
            (m_axis_tuser == KIND_WAIT && m_axis_tdata[15:0] == 16'd0) ||
            (m_axis_tuser == KIND_END && m_axis_tdata == 32'd0))
        else $error("result fields inconsistent with kind");

endmodule

bind vgm_command_stream_parser vgm_checker u_vgm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
